>>> rtl/core/lzm_pkg.sv
// ----------------------------------------------------------------------------
// lzm_pkg: shared types and constants of the layer z-order manager
// Request and result codes, the probe token that walks the slot chain and the
// restack command broadcast to every slot cell.
// ----------------------------------------------------------------------------
package lzm_pkg;

  // Default pool size and fixed field widths
  localparam int unsigned LZM_NUM_LAYERS = 256;
  localparam int unsigned LAYER_W        = 8;
  localparam int unsigned HEIGHT_W       = 9;

  // Height code for a hidden layer and for an empty redraw range
  localparam logic [HEIGHT_W-1:0] HEIGHT_HIDDEN = '1;

  // Request kinds
  typedef enum logic [1:0] {
    OP_ALLOC      = 2'd0,
    OP_SET_HEIGHT = 2'd1,
    OP_FREE       = 2'd2,
    OP_NONE       = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_NO_FREE   = 2'd1,
    STAT_UNCHANGED = 2'd2,
    STAT_NOT_ALLOC = 2'd3
  } status_e;

  // Where a slot cell inside the shift range takes its new owner from
  typedef enum logic [1:0] {
    SH_NONE       = 2'd0,
    SH_FROM_LOWER = 2'd1,
    SH_FROM_UPPER = 2'd2
  } shift_e;

  // Probe token, handed from cell to cell once per cycle
  typedef struct packed {
    logic               valid;
    logic               hit;       // probed layer found in a shown slot
    logic [LAYER_W-1:0] hit_idx;   // slot (height) of the probed layer
    logic               free;      // a free layer was seen
    logic [LAYER_W-1:0] free_idx;  // lowest free layer
    logic               used;      // probed layer is allocated
  } tok_t;

  // Restack command, applied by all cells in the same cycle
  typedef struct packed {
    logic                valid;
    shift_e              shift;
    logic [HEIGHT_W-1:0] lo;       // lowest destination slot, signed
    logic [HEIGHT_W-1:0] hi;       // highest destination slot, signed
    logic                ins;
    logic [LAYER_W-1:0]  ins_idx;
    logic [LAYER_W-1:0]  ins_id;
    logic                use_set;
    logic                use_clr;
    logic [LAYER_W-1:0]  use_idx;
  } cmd_t;

  // Result fields
  typedef struct packed {
    status_e             status;
    logic [LAYER_W-1:0]  layer;
    logic [HEIGHT_W-1:0] new_h;
    logic [HEIGHT_W-1:0] old_h;
    logic [LAYER_W-1:0]  map_from;
    logic [LAYER_W-1:0]  redraw_lo;
    logic [HEIGHT_W-1:0] redraw_hi;
    logic                redraw_need;
  } rsp_t;

endpackage

>>> rtl/core/layer_zorder_manager.sv
// ----------------------------------------------------------------------------
// layer_zorder_manager: window layer z-order stack
// Allocates, restacks and frees window layers and reports the heights whose
// owner map must be rebuilt and which must be redrawn.
//
//   Channel  Dir  tuser          tdata
//   s_axis   in   op             layer_id, requested_height
//   m_axis   out  status         result_layer, new_height, old_height,
//                                map_from_height, redraw_low, redraw_high,
//                                redraw_needed
//
// For every request a probe token walks the chain of NUM_LAYERS slot cells,
// one cell per cycle, before the restack is decided.
// One request is in work at a time; the next one is taken as soon as the
// previous result sits in the output register, even if it is not yet taken.
// A stalled output holds the decided request in the sequencer until free.
// Reset clears the in-use flags and empties the stack; no clearing pass.
// ----------------------------------------------------------------------------
module layer_zorder_manager
  import lzm_pkg::*;
#(
  parameter int unsigned NUM_LAYERS = LZM_NUM_LAYERS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] layer_id, [16:8] requested_height
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [7:0] result_layer, [16:8] new_height,
                                      // [25:17] old_height, [33:26] map_from_height,
                                      // [41:34] redraw_low, [50:42] redraw_high,
                                      // [51] redraw_needed
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  tok_t                tok_w [NUM_LAYERS+1];
  logic [LAYER_W-1:0]  owner_w [NUM_LAYERS+2];
  logic [LAYER_W-1:0]  probe_id;
  logic [HEIGHT_W-1:0] top_h;
  cmd_t                cmd;
  rsp_t                rsp;

  // Sequencer
  lzm_ctrl #(
    .NUM_LAYERS (NUM_LAYERS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .req_op_i     (op_e'(s_axis_tuser)),
    .req_layer_i  (s_axis_tdata[7:0]),
    .req_height_i (s_axis_tdata[16:8]),
    .rsp_valid_o  (m_axis_tvalid),
    .rsp_ready_i  (m_axis_tready),
    .rsp_o        (rsp),
    .launch_o     (tok_w[0]),
    .probe_i      (tok_w[NUM_LAYERS]),
    .probe_id_o   (probe_id),
    .top_o        (top_h),
    .cmd_o        (cmd)
  );

  // Tie the chain ends
  assign owner_w[0]            = '0;
  assign owner_w[NUM_LAYERS+1] = '0;

  // Slot chain, cell g holds height g and the in-use flag of layer g
  for (genvar g = 0; g < NUM_LAYERS; g++) begin : g_cell
    lzm_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .tok_i         (tok_w[g]),
      .tok_o         (tok_w[g+1]),
      .lower_owner_i (owner_w[g]),
      .upper_owner_i (owner_w[g+2]),
      .owner_o       (owner_w[g+1]),
      .probe_id_i    (probe_id),
      .top_i         (top_h),
      .cmd_i         (cmd)
    );
  end

  // Pack the result
  assign m_axis_tuser = rsp.status;
  assign m_axis_tdata = {4'b0, rsp.redraw_need, rsp.redraw_hi, rsp.redraw_lo,
                         rsp.map_from, rsp.old_h, rsp.new_h, rsp.layer};

  // No restack command while a probe leaves the chain
  a_cmd_no_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.valid |-> !tok_w[NUM_LAYERS].valid)
    else $error("restack command overlaps a probe answer");

  // A probe answer never arrives while a new request may be taken
  a_ready_no_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !tok_w[NUM_LAYERS].valid)
    else $error("probe answer while idle");

  // A command never both allocates and releases
  a_use_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.valid |-> $onehot0({cmd.use_set, cmd.use_clr}))
    else $error("allocate and release in one command");

  // The inserted slot lies outside the shifted range
  a_ins_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.valid && cmd.ins && (cmd.shift != SH_NONE)) |->
      ($signed({1'b0, cmd.ins_idx}) < $signed(cmd.lo) ||
       $signed({1'b0, cmd.ins_idx}) > $signed(cmd.hi)))
    else $error("insert position inside shift range");

  // Every result follows a decided request
  a_rsp_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(1'b1) && cmd.valid)
    else $error("result without restack decision");

endmodule

>>> rtl/core/lzm_cell.sv
// ----------------------------------------------------------------------------
// lzm_cell: one slot of the z-order chain
// Holds the owner of one stacking height and the in-use flag of the layer with
// the same index. Passes the probe token on to the next cell every cycle and
// applies the broadcast restack command.
// ----------------------------------------------------------------------------
module lzm_cell
  import lzm_pkg::*;
#(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tok_t                tok_i,
  output tok_t                tok_o,
  input  logic [LAYER_W-1:0]  lower_owner_i,
  input  logic [LAYER_W-1:0]  upper_owner_i,
  output logic [LAYER_W-1:0]  owner_o,
  input  logic [LAYER_W-1:0]  probe_id_i,
  input  logic [HEIGHT_W-1:0] top_i,
  input  cmd_t                cmd_i
);

  localparam logic [LAYER_W-1:0]  IDX = LAYER_W'(CELL_IDX);
  localparam logic [HEIGHT_W-1:0] POS = {1'b0, IDX};

  logic [LAYER_W-1:0] owner_q, owner_d;
  logic               use_q, use_d;
  tok_t               tok_q, tok_d;
  logic               shown;
  logic               hit;
  logic               in_range;

  // Probe: look for the layer in shown slots, note first free, read in-use
  always_comb begin
    shown = $signed(POS) <= $signed(top_i);
    hit   = shown && (owner_q == probe_id_i);
    tok_d = tok_i;
    if (!tok_i.hit && hit) begin
      tok_d.hit     = 1'b1;
      tok_d.hit_idx = IDX;
    end
    if (!tok_i.free && !use_q) begin
      tok_d.free     = 1'b1;
      tok_d.free_idx = IDX;
    end
    tok_d.used = tok_i.used | (use_q && (probe_id_i == IDX));
  end

  // Restack: insert the moved layer or take the owner of the lower or upper neighbour
  always_comb begin
    in_range = ($signed(POS) >= $signed(cmd_i.lo)) && ($signed(POS) <= $signed(cmd_i.hi));
    owner_d  = owner_q;
    if (cmd_i.valid) begin
      if (cmd_i.ins && (cmd_i.ins_idx == IDX)) begin
        owner_d = cmd_i.ins_id;
      end else if (in_range) begin
        case (cmd_i.shift)
          SH_FROM_LOWER: owner_d = lower_owner_i;
          SH_FROM_UPPER: owner_d = upper_owner_i;
          default:       owner_d = owner_q;
        endcase
      end
    end
  end

  // Allocate and release the layer of this index
  always_comb begin
    use_d = use_q;
    if (cmd_i.valid && (cmd_i.use_idx == IDX)) begin
      if (cmd_i.use_set) begin
        use_d = 1'b1;
      end else if (cmd_i.use_clr) begin
        use_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_q <= 1'b0;
      tok_q <= '0;
    end else begin
      use_q <= use_d;
      tok_q <= tok_d;
    end
  end

  // Slot owner is undefined until written
  always_ff @(posedge clk_i) begin
    owner_q <= owner_d;
  end

  assign tok_o   = tok_q;
  assign owner_o = owner_q;

endmodule

>>> rtl/core/lzm_ctrl.sv
// ----------------------------------------------------------------------------
// lzm_ctrl: request sequencer of the z-order manager
// Takes a request, sends a probe down the slot chain, clamps the height from
// the probe answer, issues the restack command and holds the result.
// ----------------------------------------------------------------------------
module lzm_ctrl
  import lzm_pkg::*;
#(
  parameter int unsigned NUM_LAYERS = LZM_NUM_LAYERS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  op_e                 req_op_i,
  input  logic [LAYER_W-1:0]  req_layer_i,
  input  logic [HEIGHT_W-1:0] req_height_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output rsp_t                rsp_o,
  output tok_t                launch_o,
  input  tok_t                probe_i,
  output logic [LAYER_W-1:0]  probe_id_o,
  output logic [HEIGHT_W-1:0] top_o,
  output cmd_t                cmd_o
);

  localparam logic [HEIGHT_W:0]   MAX_X   = (HEIGHT_W+1)'(NUM_LAYERS - 1);
  localparam logic [HEIGHT_W-1:0] MAX_TOP = HEIGHT_W'(NUM_LAYERS - 1);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_WALK    = 3'b010,
    ST_RESOLVE = 3'b100
  } state_e;

  state_e              state_q, state_d;
  op_e                 op_q;
  logic [LAYER_W-1:0]  id_q;
  logic [HEIGHT_W-1:0] req_q;
  logic [HEIGHT_W-1:0] top_q, top_d;
  tok_t                launch_q, launch_d;
  tok_t                res_q;
  cmd_t                cmd_q, cmd_d, cmd_c;
  logic                rsp_valid_q, rsp_valid_d;
  rsp_t                rsp_q, rsp_c;
  logic                accept, fire;

  logic [HEIGHT_W-1:0] old_h, new_h;
  logic [HEIGHT_W:0]   top_x, req_x, lim_x, clamp_a, clamp_b, clamp_c;
  logic                do_show, do_hide, do_raise, do_lower;

  assign accept = req_valid_i && req_ready_o;
  assign fire   = (state_q == ST_RESOLVE) && (!rsp_valid_q || rsp_ready_i);

  // Clamp the requested height against the current stack
  always_comb begin
    old_h   = res_q.hit ? {1'b0, res_q.hit_idx} : HEIGHT_HIDDEN;
    top_x   = {top_q[HEIGHT_W-1], top_q};
    req_x   = {req_q[HEIGHT_W-1], req_q};
    lim_x   = old_h[HEIGHT_W-1] ? top_x + (HEIGHT_W+1)'(1) : top_x;
    clamp_a = ($signed(req_x) > $signed(lim_x)) ? lim_x : req_x;
    clamp_b = ($signed(clamp_a) < $signed({(HEIGHT_W+1){1'b1}})) ? '1 : clamp_a;
    clamp_c = ($signed(clamp_b) > $signed(MAX_X)) ? MAX_X : clamp_b;
    new_h   = clamp_c[HEIGHT_W-1:0];
  end

  // Decide result, restack command and new top height
  always_comb begin
    rsp_c             = '0;
    rsp_c.status      = STAT_DONE;
    rsp_c.layer       = id_q;
    rsp_c.new_h       = HEIGHT_HIDDEN;
    rsp_c.old_h       = HEIGHT_HIDDEN;
    rsp_c.redraw_hi   = HEIGHT_HIDDEN;
    cmd_c             = '0;
    cmd_c.shift       = SH_NONE;
    top_d             = top_q;
    do_show           = 1'b0;
    do_hide           = 1'b0;
    do_raise          = 1'b0;
    do_lower          = 1'b0;

    case (op_q)
      OP_ALLOC: begin
        if (res_q.free) begin
          rsp_c.layer   = res_q.free_idx;
          cmd_c.use_set = 1'b1;
          cmd_c.use_idx = res_q.free_idx;
        end else begin
          rsp_c.status = STAT_NO_FREE;
          rsp_c.layer  = '0;
        end
      end
      OP_SET_HEIGHT: begin
        if (!res_q.used) begin
          rsp_c.status = STAT_NOT_ALLOC;
        end else begin
          rsp_c.old_h = old_h;
          rsp_c.new_h = new_h;
          if (new_h == old_h) begin
            rsp_c.status = STAT_UNCHANGED;
          end else if (old_h == HEIGHT_HIDDEN) begin
            do_show = 1'b1;
          end else if (new_h == HEIGHT_HIDDEN) begin
            do_hide = 1'b1;
          end else if ($signed(old_h) < $signed(new_h)) begin
            do_raise = 1'b1;
          end else begin
            do_lower = 1'b1;
          end
        end
      end
      OP_FREE: begin
        if (!res_q.used) begin
          rsp_c.status = STAT_NOT_ALLOC;
        end else begin
          cmd_c.use_clr = 1'b1;
          cmd_c.use_idx = id_q;
          rsp_c.old_h   = old_h;
          do_hide       = (old_h != HEIGHT_HIDDEN);
        end
      end
      default: begin
        rsp_c.status = STAT_UNCHANGED;
      end
    endcase

    // Show: open a gap at the new height, stack grows by one
    if (do_show) begin
      rsp_c.redraw_need = 1'b1;
      rsp_c.map_from    = new_h[LAYER_W-1:0];
      rsp_c.redraw_lo   = new_h[LAYER_W-1:0];
      rsp_c.redraw_hi   = new_h;
      // Append on top moves nothing; its range start would not fit the field
      cmd_c.shift       = (new_h == top_q + HEIGHT_W'(1)) ? SH_NONE : SH_FROM_LOWER;
      cmd_c.lo          = new_h + HEIGHT_W'(1);
      cmd_c.hi          = top_q + HEIGHT_W'(1);
      cmd_c.ins         = 1'b1;
      cmd_c.ins_idx     = new_h[LAYER_W-1:0];
      cmd_c.ins_id      = id_q;
      if ($signed(top_q) < $signed(MAX_TOP)) begin
        top_d = top_q + HEIGHT_W'(1);
      end
    end

    // Hide: close the gap from above, stack shrinks by one
    if (do_hide) begin
      rsp_c.redraw_need = 1'b1;
      rsp_c.new_h       = HEIGHT_HIDDEN;
      rsp_c.map_from    = '0;
      rsp_c.redraw_lo   = '0;
      rsp_c.redraw_hi   = old_h - HEIGHT_W'(1);
      cmd_c.shift       = SH_FROM_UPPER;
      cmd_c.lo          = old_h;
      cmd_c.hi          = top_q - HEIGHT_W'(1);
      if (!top_q[HEIGHT_W-1]) begin
        top_d = top_q - HEIGHT_W'(1);
      end
    end

    // Raise: slots above the old height up to the new one drop by one
    if (do_raise) begin
      rsp_c.redraw_need = 1'b1;
      rsp_c.map_from    = new_h[LAYER_W-1:0];
      rsp_c.redraw_lo   = new_h[LAYER_W-1:0];
      rsp_c.redraw_hi   = new_h;
      cmd_c.shift       = SH_FROM_UPPER;
      cmd_c.lo          = old_h;
      cmd_c.hi          = new_h - HEIGHT_W'(1);
      cmd_c.ins         = 1'b1;
      cmd_c.ins_idx     = new_h[LAYER_W-1:0];
      cmd_c.ins_id      = id_q;
    end

    // Lower: slots from the new height up to below the old one climb by one
    if (do_lower) begin
      rsp_c.redraw_need = 1'b1;
      rsp_c.map_from    = new_h[LAYER_W-1:0] + LAYER_W'(1);
      rsp_c.redraw_lo   = new_h[LAYER_W-1:0] + LAYER_W'(1);
      rsp_c.redraw_hi   = old_h;
      cmd_c.shift       = SH_FROM_LOWER;
      cmd_c.lo          = new_h + HEIGHT_W'(1);
      cmd_c.hi          = old_h;
      cmd_c.ins         = 1'b1;
      cmd_c.ins_idx     = new_h[LAYER_W-1:0];
      cmd_c.ins_id      = id_q;
    end
  end

  // Sequence: accept, walk the probe, resolve when the result slot is free
  always_comb begin
    state_d        = state_q;
    launch_d       = '0;
    launch_d.valid = accept;
    cmd_d          = cmd_c;
    cmd_d.valid    = fire;
    rsp_valid_d    = rsp_valid_q;
    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
    if (fire) begin
      rsp_valid_d = 1'b1;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (probe_i.valid) begin
          state_d = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      top_q       <= HEIGHT_HIDDEN;
      launch_q    <= '0;
      cmd_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      launch_q    <= launch_d;
      cmd_q       <= cmd_d;
      rsp_valid_q <= rsp_valid_d;
      if (fire) begin
        top_q <= top_d;
      end
    end
  end

  // Hold request, probe answer and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_op_i;
      id_q  <= req_layer_i;
      req_q <= req_height_i;
    end
    if ((state_q == ST_WALK) && probe_i.valid) begin
      res_q <= probe_i;
    end
    if (fire) begin
      rsp_q <= rsp_c;
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;
  assign launch_o    = launch_q;
  assign probe_id_o  = id_q;
  assign top_o       = top_q;
  assign cmd_o       = cmd_q;

endmodule
